// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every edge once reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, including during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/core/bdpc_pkg.sv -----
// Shared types and constants of the button debounce / press classifier.
// No dependencies.
package bdpc_pkg;

  localparam int          CfgAddrW  = 5;
  localparam logic [7:0]  CountMax  = 8'd255;
  localparam int          HalfW     = 16;
  localparam int          TimeW     = 32;
  localparam int          DivSteps  = TimeW;
  localparam int          DivCntW   = $clog2(DivSteps);

  localparam logic [7:0]       DebounceRst = 8'd5;
  localparam logic [31:0]      LongRst     = 32'd1000;
  localparam logic [HalfW-1:0] SlowRst     = 16'd500;
  localparam logic [HalfW-1:0] FastRst     = 16'd100;

  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_LONG     = 3'd1,
    REG_LED_MODE = 3'd2,
    REG_SLOW     = 3'd3,
    REG_FAST     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    LED_OFF  = 2'd0,
    LED_ON   = 2'd1,
    LED_SLOW = 2'd2,
    LED_FAST = 2'd3
  } led_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic             button_level;
    logic [TimeW-1:0] time_ms;
    logic             clear_short;
    logic             clear_long;
  } in_item_t;

  typedef struct packed {
    logic button_down;
    logic short_pending;
    logic long_pending;
    logic led_on;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       debounce_ticks;
    logic [31:0]      long_press_ms;
    led_sel_t         led_mode;
    logic [HalfW-1:0] blink_slow_ms;
    logic [HalfW-1:0] blink_fast_ms;
  } cfg_t;

  typedef struct packed {
    logic load;      // take the request, update debounce state, start divide
    logic step;      // one divider step
    logic out_load;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic div_done;  // last divider step is happening this cycle
  } stat_t;

endpackage

// ----- rtl/core/bdpc_ctrl.sv -----
// Sequencer of the press classifier: request handshake, divider steps,
// output valid. Depends on bdpc_pkg.
module bdpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  bdpc_pkg::stat_t stat,
  output bdpc_pkg::cmd_t  cmd
);
  import bdpc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/bdpc_datapath.sv -----
// Datapath: debounce counter, press timing and flags, bit-serial blink
// divider and the result register. Depends on bdpc_pkg.
module bdpc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  bdpc_pkg::cfg_t     cfg,
  input  bdpc_pkg::in_item_t in_data,
  input  bdpc_pkg::cmd_t     cmd,
  output bdpc_pkg::stat_t    stat,
  output bdpc_pkg::out_item_t out_data
);
  import bdpc_pkg::*;

  // debounce / classifier state
  logic             last_r, last_nxt;
  logic             stable_r, stable_nxt;
  logic [7:0]       agree_r, agree_nxt;
  logic             primed_r, primed_nxt;
  logic             short_r, short_nxt;
  logic             long_r, long_nxt;
  logic [TimeW-1:0] press_r, press_nxt;

  // divider
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [TimeW-1:0]   dvd_r, dvd_nxt;
  logic [HalfW-1:0]   dsr_r, dsr_nxt;
  logic [HalfW-1:0]   rem_r, rem_nxt;
  logic               q_r, q_nxt;
  logic [HalfW:0]     shifted, diff;
  logic               ge;
  logic [HalfW-1:0]   half_sel;

  out_item_t out_r;

  logic             settled, moving, set_short, set_long;
  logic [TimeW-1:0] elapsed;

  always_comb begin
    if (in_data.button_level == last_r) begin
      agree_nxt = (agree_r < CountMax) ? agree_r + 8'd1 : agree_r;
    end else begin
      agree_nxt = 8'd1;
    end
    last_nxt = in_data.button_level;
    settled  = (agree_nxt >= cfg.debounce_ticks);
    moving   = settled && (last_nxt != stable_r);
    elapsed  = in_data.time_ms - press_r;

    stable_nxt = moving ? last_nxt : stable_r;
    press_nxt  = (moving && !last_nxt) ? in_data.time_ms : press_r;
    // release with a prior settled released level gets classified
    set_long   = moving && last_nxt && primed_r && (elapsed >= cfg.long_press_ms);
    set_short  = moving && last_nxt && primed_r && (elapsed < cfg.long_press_ms);
    short_nxt  = (short_r && !in_data.clear_short) || set_short;
    long_nxt   = (long_r && !in_data.clear_long) || set_long;
    primed_nxt = primed_r || (stable_nxt && settled);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b1;
      stable_r <= 1'b1;
      agree_r  <= 8'd0;
      primed_r <= 1'b0;
      short_r  <= 1'b0;
      long_r   <= 1'b0;
      press_r  <= '0;
    end else if (cmd.load) begin
      last_r   <= last_nxt;
      stable_r <= stable_nxt;
      agree_r  <= agree_nxt;
      primed_r <= primed_nxt;
      short_r  <= short_nxt;
      long_r   <= long_nxt;
      press_r  <= press_nxt;
    end
  end

  // restoring divide, one quotient bit per step; only the last bit is kept
  assign half_sel = (cfg.led_mode == LED_FAST) ? cfg.blink_fast_ms : cfg.blink_slow_ms;
  assign shifted  = {rem_r, dvd_r[TimeW-1]};
  assign diff     = shifted - {1'b0, dsr_r};
  assign ge       = (shifted >= {1'b0, dsr_r});

  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (cmd.load) begin
      cnt_nxt = '0;
      dvd_nxt = in_data.time_ms;
      dsr_nxt = (half_sel == '0) ? HalfW'(1) : half_sel;
      rem_nxt = '0;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + DivCntW'(1);
      dvd_nxt = {dvd_r[TimeW-2:0], 1'b0};
      rem_nxt = ge ? diff[HalfW-1:0] : shifted[HalfW-1:0];
      q_nxt   = ge;
    end
  end

  assign stat.div_done = cmd.step && (cnt_r == DivCntW'(DivSteps - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.button_down   <= !stable_r;
      out_r.short_pending <= short_r;
      out_r.long_pending  <= long_r;
      unique case (cfg.led_mode)
        LED_OFF:  out_r.led_on <= 1'b0;
        LED_ON:   out_r.led_on <= 1'b1;
        default:  out_r.led_on <= q_r;
      endcase
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/core/button_debounce_press_classifier.sv -----
// Top level of the button debounce / press classifier: register file,
// sequencer and datapath. Depends on bdpc_pkg, bdpc_ctrl, bdpc_datapath.
//
//   channel   direction  handshake              payload
//   in_*      in         in_valid / in_stall    in_item_t
//   out_*     out        out_valid / out_stall  out_item_t
//   cfg       in         psel/penable/pready    32-bit registers at 4*i
//
// A request passes through the accept cycle, 32 steps of the bit-serial blink
// divider (one quotient bit per cycle) and the move into the output register.
// rst_n is synchronous; it restores register defaults and debounce state.
// A finished result waits in the output register; the next request can be taken
// as soon as the previous result has moved there.
module button_debounce_press_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bdpc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bdpc_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdpc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bdpc_pkg::*;

  cfg_t     cfg_r;
  cmd_t     cmd;
  stat_t    stat;
  reg_idx_t widx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign widx   = reg_idx_t'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DebounceRst;
      cfg_r.long_press_ms  <= LongRst;
      cfg_r.led_mode       <= LED_OFF;
      cfg_r.blink_slow_ms  <= SlowRst;
      cfg_r.blink_fast_ms  <= FastRst;
    end else if (wr_en) begin
      unique case (widx)
        REG_DEBOUNCE: cfg_r.debounce_ticks <= pwdata[7:0];
        REG_LONG:     cfg_r.long_press_ms  <= pwdata;
        REG_LED_MODE: cfg_r.led_mode       <= led_sel_t'(pwdata[1:0]);
        REG_SLOW:     cfg_r.blink_slow_ms  <= pwdata[HalfW-1:0];
        REG_FAST:     cfg_r.blink_fast_ms  <= pwdata[HalfW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_DEBOUNCE: prdata = {24'd0, cfg_r.debounce_ticks};
      REG_LONG:     prdata = cfg_r.long_press_ms;
      REG_LED_MODE: prdata = {30'd0, cfg_r.led_mode};
      REG_SLOW:     prdata = {16'd0, cfg_r.blink_slow_ms};
      REG_FAST:     prdata = {16'd0, cfg_r.blink_fast_ms};
      default:      prdata = '0;
    endcase
  end

  bdpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdpc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

`include "assert_macros.svh"

  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "not busy")
  `ASSERT_CLK(a_load_when_free, clk, rst_n, cmd.out_load |-> (!out_valid || !out_stall), "result lost")
  `ASSERT_CLK(a_div_while_busy, clk, rst_n, stat.div_done |-> in_stall, "divide while idle")
  `ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")

endmodule

// ----- tb/button_debounce_press_classifier_tb.sv -----
// Testbench for button_debounce_press_classifier: drives debounce ticks and
// register writes, and checks every result against an in-bench tick predictor.
// Depends on bdpc_pkg and the RTL of the block.
module button_debounce_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdpc_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  button_debounce_press_classifier u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Register shadow, starts at reset values
  logic [7:0]  deb_ticks = DebounceRst;
  logic [31:0] long_ms   = LongRst;
  led_sel_t    led_mode  = LED_OFF;
  logic [15:0] slow_ms   = SlowRst;
  logic [15:0] fast_ms   = FastRst;

  // Debounce / classifier state
  logic        smp_last   = 1'b1;
  logic        lvl_stable = 1'b1;
  logic [7:0]  agree_cnt  = 8'd0;
  logic        primed_q   = 1'b0;
  logic        short_q    = 1'b0;
  logic        long_q     = 1'b0;
  logic [31:0] press_t    = 32'd0;

  in_item_t  item_q[$];  // requests waiting for the driver
  out_item_t tick_q[$];  // expected results, oldest first
  int        n_queued  = 0;
  int        n_checked = 0;
  int        n_errors  = 0;
  logic      in_taken  = 1'b0;

  function automatic out_item_t classify_tick(in_item_t req);
    out_item_t   res;
    logic        settled;
    logic [15:0] half;
    logic [31:0] held;
    logic [31:0] quot;
    if (req.clear_short) short_q = 1'b0;
    if (req.clear_long) long_q = 1'b0;
    if (req.button_level == smp_last) begin
      if (agree_cnt != CountMax) agree_cnt = agree_cnt + 8'd1;
    end else begin
      smp_last  = req.button_level;
      agree_cnt = 8'd1;
    end
    settled = (agree_cnt >= deb_ticks);
    if (settled && smp_last != lvl_stable) begin
      lvl_stable = smp_last;
      if (!lvl_stable) begin
        press_t = req.time_ms;
      end else if (primed_q) begin
        held = req.time_ms - press_t;  // wraps modulo 2^32
        if (held >= long_ms) long_q = 1'b1;
        else short_q = 1'b1;
      end
    end
    if (lvl_stable && settled) primed_q = 1'b1;
    res.button_down   = ~lvl_stable;
    res.short_pending = short_q;
    res.long_pending  = long_q;
    case (led_mode)
      LED_OFF: res.led_on = 1'b0;
      LED_ON:  res.led_on = 1'b1;
      default: begin
        half = (led_mode == LED_FAST) ? fast_ms : slow_ms;
        if (half == 16'd0) half = 16'd1;
        quot = req.time_ms / {16'd0, half};
        res.led_on = quot[0];
      end
    endcase
    return res;
  endfunction

  task automatic check_result(out_item_t got, out_item_t want);
    if (got.button_down !== want.button_down) begin
      $error("button_down: expected %0b, got %0b", want.button_down, got.button_down);
      n_errors++;
    end
    if (got.short_pending !== want.short_pending) begin
      $error("short_pending: expected %0b, got %0b", want.short_pending, got.short_pending);
      n_errors++;
    end
    if (got.long_pending !== want.long_pending) begin
      $error("long_pending: expected %0b, got %0b", want.long_pending, got.long_pending);
      n_errors++;
    end
    if (got.led_on !== want.led_on) begin
      $error("led_on: expected %0b, got %0b", want.led_on, got.led_on);
      n_errors++;
    end
  endtask

  // Monitor: results are checked before this edge's request is predicted
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall && rst_n;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (tick_q.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          check_result(out_data, tick_q.pop_front());
          n_checked++;
        end
      end
      if (in_valid && !in_stall) tick_q.push_back(classify_tick(in_data));
    end
  end

  // Driver: bursts of requests with random gaps; a stalled request is held
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (item_q.size() > 0) begin
        in_data  <= item_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternating free and stalled stretches, plus one long hold-off
  int   seg_left  = 0;
  logic seg_stall = 1'b0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && n_checked >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_stall = ($urandom_range(0, 9) < 4);
        seg_left  = seg_stall ? $urandom_range(1, 12) : $urandom_range(1, 60);
      end
      out_stall <= seg_stall;
      seg_left--;
    end
  end

  // Stimulus generation state
  logic [31:0] gen_t    = 32'd0;
  int          step_max = 10;

  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DEBOUNCE: deb_ticks = val[7:0];
      REG_LONG:     long_ms   = val;
      REG_LED_MODE: led_mode  = led_sel_t'(val[1:0]);
      REG_SLOW:     slow_ms   = val[15:0];
      REG_FAST:     fast_ms   = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(int deb, logic [31:0] lng, led_sel_t md, int slow, int fast);
    cfg_write(REG_DEBOUNCE, deb);
    cfg_write(REG_LONG, lng);
    cfg_write(REG_LED_MODE, {30'd0, md});
    cfg_write(REG_SLOW, slow);
    cfg_write(REG_FAST, fast);
  endtask

  task automatic push_item(logic lvl, logic [31:0] t, logic cs, logic cl);
    in_item_t req;
    req.button_level = lvl;
    req.time_ms      = t;
    req.clear_short  = cs;
    req.clear_long   = cl;
    item_q.push_back(req);
    n_queued++;
  endtask

  task automatic push_sample(logic lvl, logic const_time);
    if (!const_time) gen_t += $urandom_range(0, step_max);
    push_item(lvl, gen_t, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
  endtask

  // One press and release with bounce at both edges. With const_time the
  // pressed and released stretches each hold one time value, so the hold
  // time lands exactly on the chosen delta (threshold and its neighbors).
  task automatic gen_press();
    int          hp;
    int          hr;
    logic [31:0] delta;
    logic        const_time;
    hp = ((deb_ticks > 0) ? int'(deb_ticks) : 1) + $urandom_range(0, 6);
    hr = ((deb_ticks > 0) ? int'(deb_ticks) : 1) + $urandom_range(0, 6);
    case ($urandom_range(0, 5))
      0:       delta = long_ms - 32'd1;
      1:       delta = long_ms;
      2:       delta = long_ms + 32'd1;
      3:       delta = $urandom_range(0, 100);
      4:       delta = $urandom;
      default: delta = long_ms + $urandom_range(0, 50);
    endcase
    const_time = $urandom_range(0, 1);
    repeat ($urandom_range(0, 3)) begin
      push_sample(1'b0, const_time);
      push_sample(1'b1, const_time);
    end
    repeat (hp) push_sample(1'b0, const_time);
    if (const_time) gen_t += delta;
    repeat ($urandom_range(0, 3)) begin
      push_sample(1'b1, const_time);
      push_sample(1'b0, const_time);
    end
    repeat (hr) push_sample(1'b1, const_time);
    if (const_time) gen_t += $urandom_range(1, 100);
  endtask

  task automatic gen_noise(int n);
    logic [31:0] t;
    repeat (n) begin
      if ($urandom_range(0, 1)) begin
        t = $urandom;
      end else begin
        gen_t += $urandom_range(0, step_max);
        t = gen_t;
      end
      push_item($urandom_range(0, 1), t, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  // Block is idle once every queued request has produced its result
  task automatic drain();
    while (n_checked != n_queued) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_phase(int deb, logic [31:0] lng, led_sel_t md, int slow, int fast,
                           int smax, int n);
    int start;
    set_regs(deb, lng, md, slow, fast);
    step_max = smax;
    start = n_queued;
    while (n_queued - start < n) begin
      if ($urandom_range(0, 99) < 85) gen_press();
      else gen_noise($urandom_range(1, 8));
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: debounce of one, zero fast period (LED follows time bit 0)
    set_regs(1, 1000, LED_FAST, 500, 0);
    push_item(1'b0, 32'd0, 1'b0, 1'b0);             // press before priming
    push_item(1'b1, 32'd5, 1'b0, 1'b0);             // release before priming: no flag
    push_item(1'b0, 32'd100, 1'b0, 1'b0);
    push_item(1'b1, 32'd1099, 1'b0, 1'b0);          // one below threshold: short
    push_item(1'b0, 32'd2000, 1'b1, 1'b0);
    push_item(1'b1, 32'd3000, 1'b0, 1'b0);          // exactly threshold: long
    push_item(1'b0, 32'hFFFF_FF00, 1'b0, 1'b1);
    push_item(1'b1, 32'h0000_02E7, 1'b0, 1'b0);     // wrapped time: short
    push_item(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_item(1'b1, 32'h0000_03E7, 1'b0, 1'b1);     // clear with long release
    push_item(1'b0, 32'd5000, 1'b1, 1'b0);
    push_item(1'b1, 32'd5001, 1'b1, 1'b0);          // clear with short release
    drain();

    // Directed: zero debounce follows every sample, zero threshold, zero slow period
    set_regs(0, 0, LED_SLOW, 0, 100);
    push_item(1'b0, 32'd0, 1'b0, 1'b0);
    push_item(1'b1, 32'd0, 1'b0, 1'b0);
    push_item(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_item(1'b0, 32'd7, 1'b0, 1'b0);
    push_item(1'b1, 32'd6, 1'b0, 1'b0);
    push_item(1'b0, 32'hAAAA_AAAA, 1'b1, 1'b1);
    push_item(1'b1, 32'h5555_5555, 1'b0, 1'b0);
    drain();

    run_phase(5, 1000, LED_OFF, 500, 100, 300, 250);
    run_phase(3, 50, LED_ON, 1, 65535, 30, 200);
    run_phase(2, 32'hFFFF_FFFF, LED_SLOW, 65535, 1, 5000, 220);
    run_phase(255, 300, LED_FAST, 7, 65535, 5, 500);
    run_phase(1, 20, LED_FAST, 13, 1, 40, 200);
    run_phase(0, $urandom_range(0, 500), LED_SLOW, 1, 3, 60, 200);
    repeat (3) begin
      run_phase($urandom_range(1, 8), $urandom_range(0, 2000),
                led_sel_t'($urandom_range(0, 3)),
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 65535),
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 65535),
                $urandom_range(1, 400), 100);
    end

    if (tick_q.size() != 0) begin
      $error("%0d results never arrived", tick_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
